@@ src/pcdc_pkg.sv @@
// Shared constants, types and field decoders of the pixel channel depth converter.
package pcdc_pkg;

	localparam int PIXEL_BITS        = 64;
	localparam int MAX_CHANNEL_DEPTH = 16;
	localparam int NUM_CHANNELS      = 4;
	localparam int SHIFT_FIELD_BITS  = 6;
	localparam int DEPTH_FIELD_BITS  = 5;
	localparam int SHIFT_REG_BITS    = NUM_CHANNELS * SHIFT_FIELD_BITS;
	localparam int DEPTH_REG_BITS    = NUM_CHANNELS * DEPTH_FIELD_BITS;
	localparam int CFG_DATA_BITS     = SHIFT_REG_BITS;
	localparam int CFG_INDEX_BITS    = 2;
	localparam int PROD_BITS         = 32;
	localparam int NUM_STAGES        = 5;

	localparam logic [63:0] PIXEL_MASK = {64{1'b1}} >> (64 - PIXEL_BITS);

	typedef logic [63:0]                    pixel_t;
	typedef logic [SHIFT_FIELD_BITS-1:0]    shift_t;
	typedef logic [DEPTH_FIELD_BITS-1:0]    depth_t;
	typedef logic [MAX_CHANNEL_DEPTH-1:0]   chan_t;
	typedef logic [PROD_BITS-1:0]           prod_t;
	typedef logic [SHIFT_REG_BITS-1:0]      shift_reg_t;
	typedef logic [DEPTH_REG_BITS-1:0]      depth_reg_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SRC_SHIFTS = 2'd0,
		REG_SRC_DEPTHS = 2'd1,
		REG_DST_SHIFTS = 2'd2,
		REG_DST_DEPTHS = 2'd3
	} cfg_reg_t;

	// One load enable per pipeline stage, stage 1 in bit 0.
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctl_t;

	function automatic shift_t field_shift(input shift_reg_t r, input int unsigned ch);
		return r[SHIFT_FIELD_BITS*ch +: SHIFT_FIELD_BITS];
	endfunction

	// Depth fields above the maximum saturate to the maximum.
	function automatic depth_t field_depth(input depth_reg_t r, input int unsigned ch);
		depth_t d;
		d = r[DEPTH_FIELD_BITS*ch +: DEPTH_FIELD_BITS];
		if (d > depth_t'(MAX_CHANNEL_DEPTH))
			d = depth_t'(MAX_CHANNEL_DEPTH);
		return d;
	endfunction

	function automatic chan_t ones_f(input depth_t d);
		return chan_t'(({1'b0, {MAX_CHANNEL_DEPTH{1'b0}}} | (1 << d)) - 1);
	endfunction

	// floor(2^32 / (2^d - 1)); depth 1 uses 2^32 - 1, which the correction step fixes up.
	function automatic prod_t recip_f(input depth_t d);
		prod_t m;
		case (d)
			5'd1:    m = 32'hFFFF_FFFF;
			5'd2:    m = 32'h5555_5555;
			5'd3:    m = 32'h2492_4924;
			5'd4:    m = 32'h1111_1111;
			5'd5:    m = 32'h0842_1084;
			5'd6:    m = 32'h0410_4104;
			5'd7:    m = 32'h0204_0810;
			5'd8:    m = 32'h0101_0101;
			5'd9:    m = 32'h0080_4020;
			5'd10:   m = 32'h0040_1004;
			5'd11:   m = 32'h0020_0400;
			5'd12:   m = 32'h0010_0100;
			5'd13:   m = 32'h0008_0040;
			5'd14:   m = 32'h0004_0010;
			5'd15:   m = 32'h0002_0004;
			5'd16:   m = 32'h0001_0001;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

@@ src/pcdc_if.sv @@
// Valid/ready stream interfaces for source and destination pixels.
interface pcdc_in_if;
	logic             valid;
	logic             ready;
	pcdc_pkg::pixel_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pcdc_out_if;
	logic             valid;
	logic             ready;
	pcdc_pkg::pixel_t pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink   (input valid, input pixel_out, output ready);
endinterface

@@ src/pcdc_ctrl.sv @@
// Stage valid bits and per-stage load enables of the converter pipeline.
module pcdc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	output logic                in_ready,
	output logic                out_valid,
	output pcdc_pkg::pipe_ctl_t ctl
);

	logic [pcdc_pkg::NUM_STAGES-1:0] vld_q;
	logic [pcdc_pkg::NUM_STAGES-1:0] en;

	// A stage loads when it is empty or when the stage after it loads too.
	always_comb begin
		en[pcdc_pkg::NUM_STAGES-1] = !vld_q[pcdc_pkg::NUM_STAGES-1] || out_ready;
		for (int k = pcdc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < pcdc_pkg::NUM_STAGES; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign ctl.en    = en;
	assign in_ready  = en[0];
	assign out_valid = vld_q[pcdc_pkg::NUM_STAGES-1];

endmodule

@@ src/pcdc_lane.sv @@
// One channel: extract, widen by the destination all-ones value, divide by the source one.
module pcdc_lane (
	input  logic                clk,
	input  pcdc_pkg::pipe_ctl_t ctl,
	input  pcdc_pkg::pixel_t    pixel,
	input  pcdc_pkg::shift_t    src_shift,
	input  pcdc_pkg::depth_t    src_depth,
	input  pcdc_pkg::depth_t    dst_depth,
	output pcdc_pkg::chan_t     value_s3
);

	pcdc_pkg::pixel_t  shifted;
	pcdc_pkg::chan_t   raw;
	pcdc_pkg::prod_t   prod_d;
	pcdc_pkg::prod_t   prod_s1;
	pcdc_pkg::prod_t   prod_s2;
	pcdc_pkg::prod_t   quot_s2;
	logic [63:0]       recip_prod;
	pcdc_pkg::prod_t   divisor;
	pcdc_pkg::prod_t   back_mul;
	pcdc_pkg::prod_t   remainder;
	pcdc_pkg::prod_t   quot_fix;
	logic              present;

	// Stage 1: cut the channel out and multiply by 2^dst - 1 as a shift and subtract.
	always_comb begin
		shifted = pixel >> src_shift;
		raw     = shifted[pcdc_pkg::MAX_CHANNEL_DEPTH-1:0] & pcdc_pkg::ones_f(src_depth);
		prod_d  = (pcdc_pkg::prod_t'(raw) << dst_depth) - pcdc_pkg::prod_t'(raw);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0])
			prod_s1 <= prod_d;
	end

	// Stage 2: reciprocal estimate of the quotient, low by at most one.
	assign recip_prod = 64'(prod_s1) * 64'(pcdc_pkg::recip_f(src_depth));

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			quot_s2 <= recip_prod[63:32];
			prod_s2 <= prod_s1;
		end
	end

	// Stage 3: one compare and increment; the back multiply is a shift and subtract.
	always_comb begin
		divisor   = pcdc_pkg::prod_t'(pcdc_pkg::ones_f(src_depth));
		back_mul  = (quot_s2 << src_depth) - quot_s2;
		remainder = prod_s2 - back_mul;
		quot_fix  = (remainder >= divisor) ? quot_s2 + 1'b1 : quot_s2;
		present   = (src_depth != '0) && (dst_depth != '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2])
			value_s3 <= present ? quot_fix[pcdc_pkg::MAX_CHANNEL_DEPTH-1:0] : '0;
	end

endmodule

@@ src/pcdc_pack.sv @@
// Places the four rescaled channels at their destination offsets and adds them up.
module pcdc_pack (
	input  logic                                         clk,
	input  pcdc_pkg::pipe_ctl_t                          ctl,
	input  pcdc_pkg::chan_t  [pcdc_pkg::NUM_CHANNELS-1:0] values,
	input  pcdc_pkg::shift_t [pcdc_pkg::NUM_CHANNELS-1:0] dst_shifts,
	output pcdc_pkg::pixel_t                             pixel_s5
);

	pcdc_pkg::pixel_t [pcdc_pkg::NUM_CHANNELS-1:0] placed;
	pcdc_pkg::pixel_t                              sum_a_s4;
	pcdc_pkg::pixel_t                              sum_b_s4;

	always_comb begin
		for (int ch = 0; ch < pcdc_pkg::NUM_CHANNELS; ch++) begin
			placed[ch] = pcdc_pkg::pixel_t'(values[ch]) << dst_shifts[ch];
		end
	end

	// Stage 4: two pairwise sums; stage 5: final sum, wrapping at 64 bits.
	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			sum_a_s4 <= placed[0] + placed[1];
			sum_b_s4 <= placed[2] + placed[3];
		end
		if (ctl.en[4])
			pixel_s5 <= (sum_a_s4 + sum_b_s4) & pcdc_pkg::PIXEL_MASK;
	end

endmodule

@@ src/pixel_channel_depth_converter_unit.sv @@
// Top level of the packed pixel channel depth converter.
//
//  Channel   Direction  Payload             Meaning
//  in_ch     sink       pixel_in  [63:0]    packed source pixel, one per request
//  out_ch    source     pixel_out [63:0]    repacked destination pixel, one per request
//  cfg_*     write      cfg_data  [23:0]    shift and depth registers, by cfg_index
//
// Every accepted request gives exactly one result; a new request can be taken in every
// cycle while out_ch is not stalled, so the sustained rate is one pixel per clock.
// The five stages are: extract and widen, reciprocal multiply, quotient correction,
// pairwise placement sums, and the final sum, which is the output register itself.
// Reset clears the configuration registers and the stage valid bits only.
// A stall on out_ch holds the output register; each stage still loads while it is
// empty, so bubbles close up and the input stays ready until the pipeline is full.
// Configuration is expected to change only while no request is in flight.
module pixel_channel_depth_converter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	pcdc_in_if.sink                               in_ch,
	pcdc_out_if.source                            out_ch,
	input  logic                                  cfg_we,
	input  logic [pcdc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [pcdc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// Configuration registers, as written through the write port.
	pcdc_pkg::shift_reg_t src_shifts_q;
	pcdc_pkg::depth_reg_t src_depths_q;
	pcdc_pkg::shift_reg_t dst_shifts_q;
	pcdc_pkg::depth_reg_t dst_depths_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_shifts_q <= '0;
			src_depths_q <= '0;
			dst_shifts_q <= '0;
			dst_depths_q <= '0;
		end else if (cfg_we) begin
			unique case (pcdc_pkg::cfg_reg_t'(cfg_index))
				pcdc_pkg::REG_SRC_SHIFTS: src_shifts_q <= cfg_data[pcdc_pkg::SHIFT_REG_BITS-1:0];
				pcdc_pkg::REG_SRC_DEPTHS: src_depths_q <= cfg_data[pcdc_pkg::DEPTH_REG_BITS-1:0];
				pcdc_pkg::REG_DST_SHIFTS: dst_shifts_q <= cfg_data[pcdc_pkg::SHIFT_REG_BITS-1:0];
				pcdc_pkg::REG_DST_DEPTHS: dst_depths_q <= cfg_data[pcdc_pkg::DEPTH_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Per-channel fields. Depths arrive already saturated to the maximum channel depth.
	pcdc_pkg::shift_t [pcdc_pkg::NUM_CHANNELS-1:0] src_shift;
	pcdc_pkg::depth_t [pcdc_pkg::NUM_CHANNELS-1:0] src_depth;
	pcdc_pkg::shift_t [pcdc_pkg::NUM_CHANNELS-1:0] dst_shift;
	pcdc_pkg::depth_t [pcdc_pkg::NUM_CHANNELS-1:0] dst_depth;

	always_comb begin
		for (int ch = 0; ch < pcdc_pkg::NUM_CHANNELS; ch++) begin
			src_shift[ch] = pcdc_pkg::field_shift(src_shifts_q, ch);
			src_depth[ch] = pcdc_pkg::field_depth(src_depths_q, ch);
			dst_shift[ch] = pcdc_pkg::field_shift(dst_shifts_q, ch);
			dst_depth[ch] = pcdc_pkg::field_depth(dst_depths_q, ch);
		end
	end

	// Pipeline control: valid bits travel alongside the data stages below.
	pcdc_pkg::pipe_ctl_t ctl;

	pcdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.ctl       (ctl)
	);

	// Bits at and above the pixel width are ignored on the way in.
	pcdc_pkg::pixel_t pixel_masked;
	assign pixel_masked = in_ch.pixel_in & pcdc_pkg::PIXEL_MASK;

	// Four channel lanes in parallel, each three stages deep.
	pcdc_pkg::chan_t [pcdc_pkg::NUM_CHANNELS-1:0] value_s3;

	for (genvar ch = 0; ch < pcdc_pkg::NUM_CHANNELS; ch++) begin : g_lane
		pcdc_lane u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.pixel     (pixel_masked),
			.src_shift (src_shift[ch]),
			.src_depth (src_depth[ch]),
			.dst_depth (dst_depth[ch]),
			.value_s3  (value_s3[ch])
		);
	end

	// Placement and summation; the last stage doubles as the output register.
	pcdc_pack u_pack (
		.clk        (clk),
		.ctl        (ctl),
		.values     (value_s3),
		.dst_shifts (dst_shift),
		.pixel_s5   (out_ch.pixel_out)
	);

endmodule

@@ src/pcdc_checker.sv @@
// Port-level checks of the converter, bound to the top level.
module pcdc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input pcdc_pkg::pixel_t pixel_out
);

	localparam int CNT_BITS = $clog2(pcdc_pkg::NUM_STAGES + 1);

	logic [CNT_BITS-1:0] inflight_q;
	logic                in_acc;
	logic                out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_acc && !out_acc)
			inflight_q <= inflight_q + 1'b1;
		else if (out_acc && !in_acc)
			inflight_q <= inflight_q - 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out))
		else $error("output request changed while stalled");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_BITS'(pcdc_pkg::NUM_STAGES))
		else $error("more requests in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result offered with no request in flight");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while output stage is empty");

endmodule

bind pixel_channel_depth_converter_unit pcdc_checker u_pcdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.pixel_out (out_ch.pixel_out)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the packed pixel channel depth converter.
module tb_top;
	import pcdc_pkg::*;

	// A run with no request moving on either side for this many cycles has hung.
	// The longest correct quiet stretch is the long receiver hold-off.
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int RANDOM_PHASES   = 12;
	localparam int PHASE_PIXELS    = 75;

	logic clk;
	logic arst_n;

	pcdc_in_if  in_ch();
	pcdc_out_if out_ch();

	logic                     cfg_we;
	cfg_reg_t                 cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// The testbench's own copy of the format registers, updated as each write lands.
	shift_reg_t src_shifts;
	depth_reg_t src_depths;
	shift_reg_t dst_shifts;
	depth_reg_t dst_depths;

	// Source pixels still to be offered, and the repacked pixels owed by the block.
	pixel_t pending_pixels[$];
	pixel_t expected_pixels[$];

	int error_count;
	int in_gap;
	int out_gap;
	int hold_off_left;
	int quiet_cycles;
	bit in_idle_on;
	bit out_idle_on;

	pixel_channel_depth_converter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock, reset and the known starting value of every input of the block.
	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.pixel_in   = '0;
		out_ch.ready     = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_SRC_SHIFTS;
		cfg_data         = '0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		error_count++;
	endtask

	// A depth field above the widest channel counts as the widest channel.
	function automatic int unsigned clamped_depth(input depth_reg_t r, input int ch);
		int unsigned d;
		d = 32'(r[DEPTH_FIELD_BITS*ch +: DEPTH_FIELD_BITS]);
		return (d > MAX_CHANNEL_DEPTH) ? MAX_CHANNEL_DEPTH : d;
	endfunction

	// Repacks one source pixel under the current format registers. Each channel is cut
	// out, rescaled by v * (2^dst - 1) / (2^src - 1) with the full product kept before
	// the division, and added in at its destination offset; bits pushed above bit 63
	// are lost and overlapping channels carry into each other.
	function automatic pixel_t convert_pixel(input pixel_t raw);
		pixel_t      pix;
		pixel_t      sum;
		pixel_t      chan;
		int unsigned sd;
		int unsigned dd;
		pix = raw & PIXEL_MASK;
		sum = '0;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			sd = clamped_depth(src_depths, ch);
			dd = clamped_depth(dst_depths, ch);
			if (sd != 0 && dd != 0) begin
				chan = (pix >> src_shifts[SHIFT_FIELD_BITS*ch +: SHIFT_FIELD_BITS])
					& ((64'd1 << sd) - 64'd1);
				chan = (chan * ((64'd1 << dd) - 64'd1)) / ((64'd1 << sd) - 64'd1);
				sum  = sum + (chan << dst_shifts[SHIFT_FIELD_BITS*ch +: SHIFT_FIELD_BITS]);
			end
		end
		return sum & PIXEL_MASK;
	endfunction

	// Sender: holds a request until it is taken, then waits its drawn gap before the next.
	// The expected pixel is worked out at the very edge that accepts the request.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_pixels.push_back(convert_pixel(in_ch.pixel_in));
			if (in_ch.valid && !in_ch.ready) begin
				// Stalled: keep offering the same pixel.
			end else if (in_gap > 0) begin
				in_gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_pixels.size() != 0) begin
				in_ch.valid    <= 1'b1;
				in_ch.pixel_in <= pending_pixels.pop_front();
				in_gap = in_idle_on ? $urandom_range(0, 7) : 0;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each accepted result against the oldest expectation, then drops
	// ready for its drawn gap. A long hold-off, when one is asked for, overrides the gaps
	// so that the pipeline fills and the sender sees its input stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pixels.size() == 0)
					report_mismatch($sformatf("pixel_out %h arrived with nothing owed",
						out_ch.pixel_out));
				else if (out_ch.pixel_out !== expected_pixels[0])
					report_mismatch($sformatf("pixel_out got %h, wanted %h",
						out_ch.pixel_out, expected_pixels[0]));
				if (expected_pixels.size() != 0)
					void'(expected_pixels.pop_front());
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ch.ready <= 1'b0;
			end else if (out_ch.valid && out_ch.ready) begin
				out_gap = out_idle_on ? $urandom_range(0, 7) : 0;
				out_ch.ready <= (out_gap == 0);
			end else if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= (out_gap == 0);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: any accepted request or register write counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("pixel_channel_depth_converter_unit: mismatch");
				$finish;
			end
		end
	end

	// One register write, done only while the block is idle. The local copy follows the
	// write at the edge where it lands; depth registers keep only their low 20 bits.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_SHIFTS: src_shifts = value[SHIFT_REG_BITS-1:0];
			REG_SRC_DEPTHS: src_depths = value[DEPTH_REG_BITS-1:0];
			REG_DST_SHIFTS: dst_shifts = value[SHIFT_REG_BITS-1:0];
			REG_DST_DEPTHS: dst_depths = value[DEPTH_REG_BITS-1:0];
			default: ;
		endcase
	endtask

	// Depth writes carry random bits above the depth fields, which the block must drop.
	task automatic load_format(input shift_reg_t ss, input depth_reg_t sd,
		input shift_reg_t ds, input depth_reg_t dd);
		write_reg(REG_SRC_SHIFTS, ss);
		write_reg(REG_SRC_DEPTHS,
			{(CFG_DATA_BITS - DEPTH_REG_BITS)'($urandom_range(0, 15)), sd});
		write_reg(REG_DST_SHIFTS, ds);
		write_reg(REG_DST_DEPTHS,
			{(CFG_DATA_BITS - DEPTH_REG_BITS)'($urandom_range(0, 15)), dd});
		@(negedge clk);
	endtask

	// Waits, sampling between edges, until every pixel has gone in and come back out,
	// then leaves the clock running idle before the format may change.
	task automatic wait_until_drained();
		@(negedge clk);
		while (pending_pixels.size() != 0 || in_ch.valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (NUM_STAGES + 2) @(posedge clk);
	endtask

	// Mostly full random, with solid and single-bit pixels mixed in.
	function automatic pixel_t random_pixel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly legal depths, with absent and oversized fields now and then.
	function automatic depth_reg_t random_depths();
		depth_reg_t r;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			case ($urandom_range(0, 9))
				0:       r[DEPTH_FIELD_BITS*ch +: DEPTH_FIELD_BITS] = '0;
				1:       r[DEPTH_FIELD_BITS*ch +: DEPTH_FIELD_BITS] =
					depth_t'($urandom_range(17, 31));
				default: r[DEPTH_FIELD_BITS*ch +: DEPTH_FIELD_BITS] =
					depth_t'($urandom_range(1, 16));
			endcase
		end
		return r;
	endfunction

	// Offsets are mostly low enough for a whole channel to fit, sometimes anywhere.
	function automatic shift_reg_t random_shifts();
		shift_reg_t r;
		for (int ch = 0; ch < NUM_CHANNELS; ch++)
			r[SHIFT_FIELD_BITS*ch +: SHIFT_FIELD_BITS] = ($urandom_range(0, 3) == 0) ?
				shift_t'($urandom_range(0, 63)) : shift_t'($urandom_range(0, 48));
		return r;
	endfunction

	initial begin
		src_shifts    = '0;
		src_depths    = '0;
		dst_shifts    = '0;
		dst_depths    = '0;
		error_count   = 0;
		in_gap        = 0;
		out_gap       = 0;
		hold_off_left = 0;
		quiet_cycles  = 0;
		in_idle_on    = 1'b0;
		out_idle_on   = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Straight after reset every depth is zero, so every channel is absent and the
		// output must be all zeros whatever goes in.
		pending_pixels.push_back('0);
		pending_pixels.push_back('1);
		pending_pixels.push_back(64'h0123_4567_89AB_CDEF);
		wait_until_drained();

		// The everyday case: 8-bit RGBA narrowed to 5-6-5 with the alpha channel dropped.
		load_format({6'd24, 6'd16, 6'd8, 6'd0}, {5'd8, 5'd8, 5'd8, 5'd8},
			{6'd0, 6'd0, 6'd5, 6'd11}, {5'd0, 5'd5, 5'd6, 5'd5});
		pending_pixels.push_back('0);
		pending_pixels.push_back('1);
		pending_pixels.push_back(64'h0000_0000_FF00_FF00);
		pending_pixels.push_back(64'hAAAA_AAAA_5555_5555);
		wait_until_drained();

		// Every field at its top value: offsets of 63 and depths that saturate to 16.
		load_format('1, '1, '1, '1);
		pending_pixels.push_back('1);
		pending_pixels.push_back(64'h8000_0000_0000_0000);
		wait_until_drained();

		// Placement near the top of the word, so the upper bits of the three higher-placed channels fall off.
		load_format({6'd48, 6'd32, 6'd16, 6'd0}, '1, {6'd63, 6'd62, 6'd56, 6'd48}, '1);
		pending_pixels.push_back('1);
		pending_pixels.push_back(64'h1234_5678_9ABC_DEF0);
		wait_until_drained();

		// All four channels land on bit 0, so their sum carries between them.
		load_format({6'd48, 6'd32, 6'd16, 6'd0}, {5'd16, 5'd16, 5'd16, 5'd16},
			'0, {5'd16, 5'd16, 5'd16, 5'd16});
		pending_pixels.push_back('1);
		pending_pixels.push_back(64'hFFFF_8000_7FFF_0001);
		wait_until_drained();

		// Widening from one bit to sixteen and narrowing the other way.
		load_format({6'd48, 6'd32, 6'd16, 6'd0}, {5'd16, 5'd1, 5'd16, 5'd1},
			{6'd48, 6'd32, 6'd16, 6'd0}, {5'd1, 5'd16, 5'd1, 5'd16});
		pending_pixels.push_back('1);
		pending_pixels.push_back(64'h8000_0001_7FFF_0001);
		pending_pixels.push_back(64'h7FFF_0000_8000_0000);
		wait_until_drained();

		// A channel absent on one side only contributes nothing.
		load_format({6'd24, 6'd16, 6'd8, 6'd0}, {5'd0, 5'd8, 5'd8, 5'd8},
			{6'd24, 6'd16, 6'd8, 6'd0}, {5'd8, 5'd8, 5'd0, 5'd8});
		pending_pixels.push_back('1);
		pending_pixels.push_back(64'h0000_0000_C3A5_5A3C);
		wait_until_drained();

		// Random formats and pixels. The idling pattern turns over from phase to phase,
		// so some phases run back to back on both sides and others stall either side.
		// One phase holds the receiver off for a long stretch while the sender keeps
		// offering, so the pipeline fills and the input has to stall.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			load_format(random_shifts(), random_depths(), random_shifts(), random_depths());
			// Every third phase rewrites one register alone on top of the new format.
			if (phase % 3 == 2) begin
				write_reg(REG_DST_DEPTHS, '1);
				@(negedge clk);
			end
			in_idle_on  = phase[0];
			out_idle_on = phase[1];
			if (phase == 4)
				hold_off_left = HOLD_OFF_CYCLES;
			for (int i = 0; i < PHASE_PIXELS; i++)
				pending_pixels.push_back(random_pixel());
			wait_until_drained();
		end

		while (expected_pixels.size() != 0) begin
			report_mismatch($sformatf("pixel_out %h never arrived", expected_pixels[0]));
			void'(expected_pixels.pop_front());
		end
		if (error_count == 0)
			$display("pixel_channel_depth_converter_unit: match");
		else
			$display("pixel_channel_depth_converter_unit: mismatch");
		$finish;
	end

endmodule
